[hdl/tiq_pkg.sv]
// shared types and constants for the timed input qualifier
package tiq_pkg;

  // sample and register field widths
  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned THR_W        = 16;
  localparam int unsigned TMR_W        = 16;
  localparam int unsigned SCALE_W      = 8;
  localparam int unsigned PROD_W       = TMR_W + SCALE_W;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned BITPOS_W     = 4;

  // bit index width for digital mode
  localparam int unsigned IDX_W = (SAMPLE_WIDTH > 1) ? $clog2(SAMPLE_WIDTH) : 1;

  // width that holds any sample or threshold, signed, plus negation headroom
  localparam int unsigned EXT_W = ((SAMPLE_WIDTH > THR_W) ? SAMPLE_WIDTH : THR_W) + 2;

  // classification queue depth (power of two)
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE       = 3'd0,
    CFG_TEST_MODE    = 3'd1,
    CFG_THRESHOLD    = 3'd2,
    CFG_TIMEOUT      = 3'd3,
    CFG_TIME_SCALE   = 3'd4,
    CFG_LATCH_MODE   = 3'd5,
    CFG_BIT_POSITION = 3'd6
  } cfg_reg_e;

  // condition tests
  typedef enum logic [2:0] {
    TEST_DIGITAL      = 3'd0,
    TEST_ABOVE        = 3'd1,
    TEST_BELOW        = 3'd2,
    TEST_ABS_ABOVE    = 3'd3,
    TEST_ZONE         = 3'd4,
    TEST_SIGNED_ABOVE = 3'd5,
    TEST_SIGNED_BELOW = 3'd6
  } test_mode_e;

  // what the front decided about one sample
  typedef enum logic [1:0] {
    CLS_DISABLED = 2'd0,
    CLS_ACTIVE   = 2'd1,
    CLS_INACTIVE = 2'd2,
    CLS_HOLD     = 2'd3
  } class_e;

  // live configuration
  typedef struct packed {
    logic                enable;
    test_mode_e          test_mode;
    logic [THR_W-1:0]    threshold;
    logic [TMR_W-1:0]    timeout;
    logic [SCALE_W-1:0]  time_scale;
    logic                latch_mode;
  } cfg_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[hdl/tiq_front.sv]
// front end: classifies one sample against the configured test
module tiq_front (
  input  tiq_pkg::cfg_t                          cfg_i,
  input  logic [tiq_pkg::SAMPLE_WIDTH-1:0]       sample_i,
  output tiq_pkg::class_e                        class_o
);

  logic signed [tiq_pkg::EXT_W-1:0] s_ext;
  logic signed [tiq_pkg::EXT_W-1:0] t_ext;
  logic signed [tiq_pkg::EXT_W-1:0] neg_t_ext;
  logic        [tiq_pkg::EXT_W-1:0] u_ext;
  logic        [tiq_pkg::EXT_W-1:0] tu_ext;
  logic        [tiq_pkg::EXT_W-1:0] mag;
  logic        [tiq_pkg::THR_W-2:0] bit_idx;
  logic                             idx_in_range;
  logic                             sel_bit;

  // signed and unsigned views of sample and threshold
  assign s_ext     = tiq_pkg::EXT_W'($signed(sample_i));
  assign t_ext     = tiq_pkg::EXT_W'($signed(cfg_i.threshold));
  assign neg_t_ext = -t_ext;
  assign u_ext     = tiq_pkg::EXT_W'(sample_i);
  assign tu_ext    = tiq_pkg::EXT_W'(cfg_i.threshold);
  assign mag       = s_ext[tiq_pkg::EXT_W-1] ? tiq_pkg::EXT_W'(-s_ext)
                                             : tiq_pkg::EXT_W'(s_ext);

  // digital mode bit pick, out of range reads as zero
  assign bit_idx      = cfg_i.threshold[tiq_pkg::THR_W-1:1];
  assign idx_in_range = (bit_idx < (tiq_pkg::THR_W-1)'(tiq_pkg::SAMPLE_WIDTH));
  assign sel_bit      = idx_in_range & sample_i[bit_idx[tiq_pkg::IDX_W-1:0]];

  // classification
  always_comb begin
    class_o = tiq_pkg::CLS_INACTIVE;
    if (!cfg_i.enable) begin
      class_o = tiq_pkg::CLS_DISABLED;
    end else begin
      case (cfg_i.test_mode)
        tiq_pkg::TEST_DIGITAL: begin
          if (sel_bit == cfg_i.threshold[0]) class_o = tiq_pkg::CLS_ACTIVE;
        end
        tiq_pkg::TEST_ABOVE: begin
          if (u_ext > tu_ext) class_o = tiq_pkg::CLS_ACTIVE;
        end
        tiq_pkg::TEST_BELOW: begin
          if (u_ext < tu_ext) class_o = tiq_pkg::CLS_ACTIVE;
        end
        tiq_pkg::TEST_ABS_ABOVE: begin
          if (mag > tu_ext) class_o = tiq_pkg::CLS_ACTIVE;
        end
        tiq_pkg::TEST_ZONE: begin
          if (s_ext >= t_ext) class_o = tiq_pkg::CLS_ACTIVE;
          else if (s_ext <= neg_t_ext) class_o = tiq_pkg::CLS_INACTIVE;
          else class_o = tiq_pkg::CLS_HOLD;
        end
        tiq_pkg::TEST_SIGNED_ABOVE: begin
          if (s_ext > t_ext) class_o = tiq_pkg::CLS_ACTIVE;
        end
        tiq_pkg::TEST_SIGNED_BELOW: begin
          if (s_ext < t_ext) class_o = tiq_pkg::CLS_ACTIVE;
        end
        default: begin
          class_o = tiq_pkg::CLS_INACTIVE;
        end
      endcase
    end
  end

endmodule

[hdl/tiq_fifo.sv]
// short queue of classified beats between front and back
module tiq_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tiq_pkg::class_e      push_data_i,
  input  logic                 pop_i,
  output tiq_pkg::class_e      pop_data_o,
  output tiq_pkg::fifo_stat_t  status_o
);

  tiq_pkg::class_e            mem_q [tiq_pkg::FIFO_DEPTH];
  logic [tiq_pkg::PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [tiq_pkg::PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [tiq_pkg::PTR_W:0]    cnt_q, cnt_d;

  // status and head
  assign status_o.full  = (cnt_q == (tiq_pkg::PTR_W+1)'(tiq_pkg::FIFO_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q + (tiq_pkg::PTR_W)'(push_i);
    rd_ptr_d = rd_ptr_q + (tiq_pkg::PTR_W)'(pop_i);
    cnt_d    = cnt_q + (tiq_pkg::PTR_W+1)'(push_i) - (tiq_pkg::PTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hdl/tiq_back.sv]
// back end: timer, qualified flag and the result register
module tiq_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tiq_pkg::cfg_t                   cfg_i,
  input  tiq_pkg::class_e                 class_i,
  input  tiq_pkg::fifo_stat_t             fifo_stat_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            set_request_o,
  output logic                            clear_request_o,
  output logic                            qualified_o,
  output logic [tiq_pkg::TMR_W-1:0]       count_o
);

  logic [tiq_pkg::PROD_W-1:0] prod;
  logic [tiq_pkg::TMR_W-1:0]  limit_q, limit_d;
  logic [tiq_pkg::TMR_W-1:0]  timer_q, timer_d;
  logic [tiq_pkg::TMR_W:0]    timer_inc;
  logic                       flag_q, flag_d;
  logic                       set_q, set_d;
  logic                       clr_q, clr_d;
  logic                       valid_q, valid_d;

  // saturated limit, registered after the multiply
  assign prod    = tiq_pkg::PROD_W'(cfg_i.timeout) * tiq_pkg::PROD_W'(cfg_i.time_scale);
  assign limit_d = (prod[tiq_pkg::PROD_W-1:tiq_pkg::TMR_W] != '0) ? '1
                                                                   : prod[tiq_pkg::TMR_W-1:0];

  // take the queue head when the result register is free or draining
  assign pop_o     = !fifo_stat_i.empty && (!valid_q || !out_stall_i);
  assign timer_inc = (tiq_pkg::TMR_W+1)'(timer_q) + 1'b1;

  // timer and flag update for one beat
  always_comb begin
    timer_d = timer_q;
    flag_d  = flag_q;
    set_d   = set_q;
    clr_d   = clr_q;
    valid_d = valid_q & out_stall_i;
    if (pop_o) begin
      valid_d = 1'b1;
      set_d   = 1'b0;
      clr_d   = 1'b0;
      case (class_i)
        tiq_pkg::CLS_DISABLED: begin
          clr_d   = !cfg_i.latch_mode;
          flag_d  = 1'b0;
          timer_d = '0;
        end
        tiq_pkg::CLS_ACTIVE: begin
          if (timer_inc >= (tiq_pkg::TMR_W+1)'(limit_q)) begin
            timer_d = limit_q;
            set_d   = !cfg_i.latch_mode || !flag_q;
            flag_d  = 1'b1;
          end else begin
            timer_d = timer_inc[tiq_pkg::TMR_W-1:0];
          end
        end
        tiq_pkg::CLS_INACTIVE: begin
          if (timer_q != '0) begin
            timer_d = timer_q - 1'b1;
          end else begin
            clr_d  = !cfg_i.latch_mode;
            flag_d = 1'b0;
          end
        end
        tiq_pkg::CLS_HOLD: begin
          // between the zone thresholds nothing moves
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      timer_q <= '0;
      flag_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      limit_q <= limit_d;
      timer_q <= timer_d;
      flag_q  <= flag_d;
      valid_q <= valid_d;
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    set_q <= set_d;
    clr_q <= clr_d;
  end

  assign out_valid_o     = valid_q;
  assign set_request_o   = set_q;
  assign clear_request_o = clr_q;
  assign qualified_o     = flag_q;
  assign count_o         = timer_q;

endmodule

[hdl/timed_input_qualifier.sv]
// top level of the timed input qualifier
// The qualifier takes one sample beat per clock and returns one result beat for
// each: on acceptance the sample is classified into a two-entry queue, and the
// back end updates the timer and flag from the queue head and loads the result
// register. Sustained rate is one beat per cycle; the input stalls only when
// the queue is full, which happens only after the output has stalled. The
// limit timeout * time_scale comes from one registered 16x8 multiplier after
// the configuration register. The configuration port is always ready; the user
// must ensure registers are written only while no beat is in flight; the block
// does not enforce it. The status bit position is accepted but changes no result.
module timed_input_qualifier (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tiq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tiq_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // sample channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [tiq_pkg::SAMPLE_WIDTH-1:0]   sample_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               set_request_o,
  output logic                               clear_request_o,
  output logic                               qualified_o,
  output logic [tiq_pkg::TMR_W-1:0]          count_o
);

  tiq_pkg::cfg_t       cfg_q, cfg_d;
  tiq_pkg::class_e     front_class;
  tiq_pkg::class_e     head_class;
  tiq_pkg::fifo_stat_t fifo_stat;
  logic                push;
  logic                pop;
  logic                cfg_wr;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (tiq_pkg::cfg_reg_e'(cfg_index_i))
        tiq_pkg::CFG_ENABLE:     cfg_d.enable     = cfg_data_i[0];
        tiq_pkg::CFG_TEST_MODE:  cfg_d.test_mode  = tiq_pkg::test_mode_e'(cfg_data_i[2:0]);
        tiq_pkg::CFG_THRESHOLD:  cfg_d.threshold  = cfg_data_i[tiq_pkg::THR_W-1:0];
        tiq_pkg::CFG_TIMEOUT:    cfg_d.timeout    = cfg_data_i[tiq_pkg::TMR_W-1:0];
        tiq_pkg::CFG_TIME_SCALE: cfg_d.time_scale = cfg_data_i[tiq_pkg::SCALE_W-1:0];
        tiq_pkg::CFG_LATCH_MODE: cfg_d.latch_mode = cfg_data_i[0];
        tiq_pkg::CFG_BIT_POSITION: begin
          // status bit routing lives outside this block
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable     <= 1'b1;
      cfg_q.test_mode  <= tiq_pkg::TEST_BELOW;
      cfg_q.threshold  <= '0;
      cfg_q.timeout    <= '0;
      cfg_q.time_scale <= tiq_pkg::SCALE_W'(1);
      cfg_q.latch_mode <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: classify on accept
  assign in_stall_o = fifo_stat.full;
  assign push       = in_valid_i && !in_stall_o;

  tiq_front u_front (
    .cfg_i    (cfg_q),
    .sample_i (sample_i),
    .class_o  (front_class)
  );

  // queue between front and back
  tiq_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_class),
    .pop_i       (pop),
    .pop_data_o  (head_class),
    .status_o    (fifo_stat)
  );

  // back: timer, flag and result register
  tiq_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .class_i         (head_class),
    .fifo_stat_i     (fifo_stat),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .set_request_o   (set_request_o),
    .clear_request_o (clear_request_o),
    .qualified_o     (qualified_o),
    .count_o         (count_o)
  );

  // a result never asks to set and clear at once
  a_req_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(set_request_o && clear_request_o))
    else $error("set and clear requested in the same beat");

  // a set request leaves the flag up
  a_set_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && set_request_o) |-> qualified_o)
    else $error("set request without qualified flag");

  // a clear request comes only with the flag down and the timer at zero
  a_clr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clear_request_o) |-> (!qualified_o && count_o == '0))
    else $error("clear request with timer or flag still set");

  // the queue cannot be full and empty together
  a_fifo_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_stat.full && fifo_stat.empty))
    else $error("queue reports full and empty");

endmodule
